### rtl/core/htwd_pkg.sv
package htwd_pkg;

  // Table geometry.
  localparam int NODE_COUNT   = 256;
  localparam int NODE_AW      = $clog2(NODE_COUNT);
  localparam int USED_W       = NODE_AW + 1;
  localparam int MAX_CODE_LEN = 32;

  // Fixed field widths.
  localparam int SYM_W    = 7;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int VBITS_W  = 4;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 2;

  // Longest insert path that is walked.
  localparam int EFF_MAX_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DECODE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_SYMBOL  = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  // One entry of the node table; a child index of zero means no child.
  typedef struct packed {
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
    logic [SYM_W-1:0]   sym;
  } node_t;

  // Request from the walker to the result buffer.
  typedef struct packed {
    logic              push;
    logic [SYM_W-1:0]  sym;
    logic [STAT_W-1:0] status;
    logic              flush;
  } res_req_t;

endpackage

### rtl/core/huffman_tree_walk_decoder.sv
// Channel   Ports                                   Transfer
// input     start, busy, in_req_type .. in_valid_bits  start high while busy low
// result    out_valid, out_symbol, out_status, out_last  one cycle strobe, no stall
//
// After reset the block writes the root entry in S_INIT (busy high).
// A clear transaction is done from the idle state and does not raise busy.
// An insert walks the path step by step, with an S_ALLOC step for each new node.
// A decode loads the walk position entry, then walks the bits and restarts at the
// root after each symbol, using the single read port of the node table (one node read per bit).
// The receiver cannot stall; each result leaves on a one-cycle strobe.
module huffman_tree_walk_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [htwd_pkg::REQ_W-1:0]  in_req_type,
  input  logic [htwd_pkg::SYM_W-1:0]  in_symbol,
  input  logic [htwd_pkg::CODE_W-1:0] in_code_bits,
  input  logic [htwd_pkg::LEN_W-1:0]  in_code_len,
  input  logic [htwd_pkg::BYTE_W-1:0] in_data_byte,
  input  logic [htwd_pkg::VBITS_W-1:0] in_valid_bits,
  output logic                        out_valid,
  output logic [htwd_pkg::SYM_W-1:0]  out_symbol,
  output logic [htwd_pkg::STAT_W-1:0] out_status,
  output logic                        out_last
);
  import htwd_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_INS, S_ALLOC, S_DLOAD, S_DWALK
  } state_t;

  state_t              state_r, state_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;
  logic [NODE_AW-1:0]  walk_r, walk_nxt;
  node_t               root_r, root_nxt;
  node_t               hold_r, hold_nxt;
  logic [NODE_AW-1:0]  cur_idx_r, cur_idx_nxt;
  logic [NODE_AW-1:0]  child_r, child_nxt;
  logic                have_rd_r, have_rd_nxt;
  logic [CODE_W-1:0]   shift_r, shift_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [VBITS_W-1:0]  rem_r, rem_nxt;

  // Node table, one write and one read port, registered read data.
  node_t               node_mem [NODE_COUNT];
  node_t               rd_q;
  logic [NODE_AW-1:0]  rd_addr;
  logic                mem_we;
  logic [NODE_AW-1:0]  mem_wa;
  node_t               mem_wd;

  res_req_t            res_req;
  node_t               base;
  logic [NODE_AW-1:0]  base_idx;
  logic [NODE_AW-1:0]  child;
  logic                leaf_hit;
  logic                accept;
  logic [LEN_W-1:0]    eff_len;
  node_t               parent_upd;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_wa] <= mem_wd;
    end
    rd_q <= node_mem[rd_addr];
  end

  // Current node: the root after a leaf, fresh read data, or the held copy when no read is pending.
  always_comb begin
    leaf_hit = have_rd_r && (state_r == S_DWALK) &&
               (rd_q.left == '0) && (rd_q.right == '0);
    if (leaf_hit) begin
      base     = root_r;
      base_idx = '0;
    end else if (have_rd_r) begin
      base     = rd_q;
      base_idx = child_r;
    end else begin
      base     = hold_r;
      base_idx = cur_idx_r;
    end
  end

  // The path bit and the byte bit both sit at the top of their shift registers.
  assign child = ((state_r == S_INS) ? shift_r[CODE_W-1] : byte_r[BYTE_W-1])
                 ? base.right : base.left;

  assign eff_len = (in_code_len > LEN_W'(EFF_MAX_LEN)) ? LEN_W'(EFF_MAX_LEN)
                                                      : in_code_len;

  // Next state of the walker.
  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    walk_nxt    = walk_r;
    hold_nxt    = hold_r;
    cur_idx_nxt = cur_idx_r;
    child_nxt   = child_r;
    have_rd_nxt = have_rd_r;
    shift_nxt   = shift_r;
    cnt_nxt     = cnt_r;
    sym_nxt     = sym_r;
    byte_nxt    = byte_r;
    rem_nxt     = rem_r;
    rd_addr     = walk_r;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    res_req     = '0;
    parent_upd  = base;

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        used_nxt  = USED_W'(1);
        walk_nxt  = '0;
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_CLEAR: begin
              mem_we   = 1'b1;
              used_nxt = USED_W'(1);
              walk_nxt = '0;
            end
            REQ_INSERT: begin
              shift_nxt   = in_code_bits << (LEN_W'(CODE_W) - eff_len);
              cnt_nxt     = eff_len;
              sym_nxt     = in_symbol;
              hold_nxt    = root_r;
              cur_idx_nxt = '0;
              have_rd_nxt = 1'b0;
              state_nxt   = S_INS;
            end
            REQ_DECODE: begin
              // The walk position entry is read in this cycle.
              byte_nxt  = in_data_byte;
              rem_nxt   = (in_valid_bits > VBITS_W'(BYTE_W)) ? VBITS_W'(BYTE_W)
                                                            : in_valid_bits;
              state_nxt = S_DLOAD;
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        if (cnt_r == '0) begin
          // End of the path: label the reached node.
          mem_we         = 1'b1;
          mem_wa         = base_idx;
          parent_upd.sym = sym_r;
          mem_wd         = parent_upd;
          res_req.push   = 1'b1;
          res_req.status = ST_DONE;
          res_req.flush  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (child != '0) begin
          rd_addr     = child;
          child_nxt   = child;
          have_rd_nxt = 1'b1;
          shift_nxt   = shift_r << 1;
          cnt_nxt     = cnt_r - LEN_W'(1);
        end else if (used_r == USED_W'(NODE_COUNT)) begin
          res_req.push   = 1'b1;
          res_req.status = ST_FULL;
          res_req.flush  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          // Link a new node into the parent; the node itself is zeroed next.
          if (shift_r[CODE_W-1]) begin
            parent_upd.right = used_r[NODE_AW-1:0];
          end else begin
            parent_upd.left = used_r[NODE_AW-1:0];
          end
          mem_we      = 1'b1;
          mem_wa      = base_idx;
          mem_wd      = parent_upd;
          cur_idx_nxt = used_r[NODE_AW-1:0];
          used_nxt    = used_r + USED_W'(1);
          hold_nxt    = '0;
          have_rd_nxt = 1'b0;
          shift_nxt   = shift_r << 1;
          cnt_nxt     = cnt_r - LEN_W'(1);
          state_nxt   = S_ALLOC;
        end
      end

      S_ALLOC: begin
        mem_we    = 1'b1;
        mem_wa    = cur_idx_r;
        state_nxt = S_INS;
      end

      S_DLOAD: begin
        hold_nxt    = rd_q;
        cur_idx_nxt = walk_r;
        have_rd_nxt = 1'b0;
        state_nxt   = S_DWALK;
      end

      S_DWALK: begin
        if (leaf_hit) begin
          // The child read last cycle is a leaf: emit it and restart at root.
          res_req.push   = 1'b1;
          res_req.sym    = rd_q.sym;
          res_req.status = ST_SYMBOL;
          hold_nxt       = root_r;
          cur_idx_nxt    = '0;
          have_rd_nxt    = 1'b0;
        end else if (rem_r != '0) begin
          byte_nxt = byte_r << 1;
          rem_nxt  = rem_r - VBITS_W'(1);
          if (child == '0) begin
            res_req.push   = 1'b1;
            res_req.status = ST_INVALID;
            hold_nxt       = root_r;
            cur_idx_nxt    = '0;
            have_rd_nxt    = 1'b0;
          end else begin
            rd_addr     = child;
            child_nxt   = child;
            have_rd_nxt = 1'b1;
          end
        end else begin
          walk_nxt      = base_idx;
          have_rd_nxt   = 1'b0;
          res_req.flush = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The root entry is mirrored so that a walk can restart without a read.
  always_comb begin
    root_nxt = root_r;
    if (mem_we && (mem_wa == '0)) begin
      root_nxt = mem_wd;
    end
  end

  // State, table bookkeeping and walk registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      used_r    <= USED_W'(1);
      walk_r    <= '0;
      root_r    <= '0;
      have_rd_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      walk_r    <= walk_nxt;
      root_r    <= root_nxt;
      have_rd_r <= have_rd_nxt;
    end
    hold_r    <= hold_nxt;
    cur_idx_r <= cur_idx_nxt;
    child_r   <= child_nxt;
    shift_r   <= shift_nxt;
    cnt_r     <= cnt_nxt;
    sym_r     <= sym_nxt;
    byte_r    <= byte_nxt;
    rem_r     <= rem_nxt;
  end

  htwd_result_buf u_result_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (res_req),
    .out_valid  (out_valid),
    .out_symbol (out_symbol),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule

### rtl/core/htwd_result_buf.sv
module htwd_result_buf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  htwd_pkg::res_req_t       req,
  output logic                     out_valid,
  output logic [htwd_pkg::SYM_W-1:0]  out_symbol,
  output logic [htwd_pkg::STAT_W-1:0] out_status,
  output logic                     out_last
);
  import htwd_pkg::*;

  logic              pend_v_r, pend_v_nxt;
  logic [SYM_W-1:0]  pend_sym_r, pend_sym_nxt;
  logic [STAT_W-1:0] pend_st_r, pend_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  out_sym_r, out_sym_nxt;
  logic [STAT_W-1:0] out_st_r, out_st_nxt;
  logic              out_last_r, out_last_nxt;

  // One result is held back until it is known whether another follows, so that
  // the final result of a transaction carries the last flag. A push together
  // with a flush only comes while nothing is held back.
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_sym_nxt  = pend_sym_r;
    pend_st_nxt   = pend_st_r;
    out_valid_nxt = 1'b0;
    out_sym_nxt   = out_sym_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    if (req.push && req.flush) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = req.sym;
      out_st_nxt    = req.status;
      out_last_nxt  = 1'b1;
      pend_v_nxt    = 1'b0;
    end else if (req.push) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt   = pend_sym_r;
        out_st_nxt    = pend_st_r;
        out_last_nxt  = 1'b0;
      end
      pend_v_nxt   = 1'b1;
      pend_sym_nxt = req.sym;
      pend_st_nxt  = req.status;
    end else if (req.flush) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt   = pend_sym_r;
        out_st_nxt    = pend_st_r;
        out_last_nxt  = 1'b1;
      end
      pend_v_nxt = 1'b0;
    end
  end

  // Control flags take the reset; the payload does not need it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_sym_r <= pend_sym_nxt;
    pend_st_r  <= pend_st_nxt;
    out_sym_r  <= out_sym_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_sym_r;
  assign out_status = out_st_r;
  assign out_last   = out_last_r;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import htwd_pkg::*;

  // The request code that the block must ignore.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 440;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [SYM_W-1:0]   sym;
    logic [CODE_W-1:0]  code;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
    logic [VBITS_W-1:0] vbits;
    logic               hold;
  } tree_cmd_t;

  typedef struct {
    logic [SYM_W-1:0]  sym;
    logic [STAT_W-1:0] status;
    logic              last;
  } walk_res_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [SYM_W-1:0]    in_symbol = '0;
  logic [CODE_W-1:0]   in_code_bits = '0;
  logic [LEN_W-1:0]    in_code_len = '0;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic [VBITS_W-1:0]  in_valid_bits = '0;
  logic                busy;
  logic                out_valid;
  logic [SYM_W-1:0]    out_symbol;
  logic [STAT_W-1:0]   out_status;
  logic                out_last;

  huffman_tree_walk_decoder u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_symbol     (in_symbol),
    .in_code_bits  (in_code_bits),
    .in_code_len   (in_code_len),
    .in_data_byte  (in_data_byte),
    .in_valid_bits (in_valid_bits),
    .out_valid     (out_valid),
    .out_symbol    (out_symbol),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  always #2 clk = ~clk;

  // Transactions waiting to be sent, and the one on the ports now.
  tree_cmd_t   cmd_q[$];
  tree_cmd_t   cur_cmd;
  int          sent_cnt = 0;

  // Shadow copy of the node table and walk state.
  logic [NODE_AW-1:0] tree_left [NODE_COUNT];
  logic [NODE_AW-1:0] tree_right [NODE_COUNT];
  logic [SYM_W-1:0]   tree_sym [NODE_COUNT];
  int unsigned        tree_used;
  int unsigned        walk_node;
  walk_res_t          walk_results[$];

  int fails = 0;
  int n_taken = 0;
  int n_sym = 0;
  int n_invalid = 0;
  int n_done = 0;
  int n_full = 0;

  function automatic void reset_tree();
    tree_left[0] = '0;
    tree_right[0] = '0;
    tree_sym[0] = '0;
    tree_used = 1;
    walk_node = 0;
  endfunction

  // Walk an insert path, allocating missing children, and label the end node.
  function automatic logic [STAT_W-1:0] grow_path(logic [SYM_W-1:0] s,
                                                  logic [CODE_W-1:0] c,
                                                  int unsigned n);
    int unsigned cur;
    int unsigned nx;
    int unsigned i;
    logic step;
    cur = 0;
    if (n > EFF_MAX_LEN) n = EFF_MAX_LEN;
    for (i = 0; i < n; i++) begin
      step = c[n - 1 - i];
      nx = step ? tree_right[cur] : tree_left[cur];
      if (nx == 0) begin
        if (tree_used >= NODE_COUNT) return ST_FULL;
        nx = tree_used;
        tree_used++;
        tree_left[nx] = '0;
        tree_right[nx] = '0;
        tree_sym[nx] = '0;
        if (step) tree_right[cur] = NODE_AW'(nx);
        else tree_left[cur] = NODE_AW'(nx);
      end
      cur = nx;
    end
    tree_sym[cur] = s;
    return ST_DONE;
  endfunction

  // Decode the leading bits of one byte from the kept walk position.
  function automatic void walk_byte(logic [BYTE_W-1:0] d, logic [VBITS_W-1:0] vb);
    walk_res_t   r;
    walk_res_t   batch[$];
    int unsigned n;
    int unsigned cur;
    int unsigned nx;
    int unsigned j;
    n = (vb > 8) ? 8 : int'(vb);
    cur = walk_node;
    r.last = 1'b0;
    for (j = 0; j < n; j++) begin
      nx = d[7 - j] ? tree_right[cur] : tree_left[cur];
      if (nx == 0) begin
        r.sym = '0;
        r.status = ST_INVALID;
        batch.insert(batch.size(), r);
        cur = 0;
      end else if (tree_left[nx] == 0 && tree_right[nx] == 0) begin
        r.sym = tree_sym[nx];
        r.status = ST_SYMBOL;
        batch.insert(batch.size(), r);
        cur = 0;
      end else begin
        cur = nx;
      end
    end
    walk_node = cur;
    if (batch.size() != 0) begin
      r = batch.pop_back();
      r.last = 1'b1;
      batch.insert(batch.size(), r);
    end
    foreach (batch[k]) walk_results.insert(walk_results.size(), batch[k]);
  endfunction

  function automatic tree_cmd_t rand_cmd(logic [REQ_W-1:0] req);
    tree_cmd_t c;
    c.req = req;
    c.sym = SYM_W'($urandom);
    c.code = $urandom;
    c.len = LEN_W'($urandom);
    c.data = BYTE_W'($urandom);
    c.vbits = VBITS_W'($urandom);
    c.hold = 1'b0;
    return c;
  endfunction

  task automatic queue_insert(input logic [SYM_W-1:0] s, input logic [CODE_W-1:0] code,
                              input int unsigned n);
    tree_cmd_t c;
    c = rand_cmd(REQ_INSERT);
    c.sym = s;
    c.code = code;
    c.len = LEN_W'(n);
    cmd_q.insert(cmd_q.size(), c);
  endtask

  task automatic queue_decode(input logic [BYTE_W-1:0] d, input int unsigned n);
    tree_cmd_t c;
    c = rand_cmd(REQ_DECODE);
    c.data = d;
    c.vbits = VBITS_W'(n);
    cmd_q.insert(cmd_q.size(), c);
  endtask

  // Driver: presents queued transactions at the falling edge, with random gaps.
  always @(negedge clk) begin
    logic was_taken;
    logic idle_ok;
    was_taken = (n_taken != sent_cnt);
    if (was_taken) begin
      cmd_q.delete(0);
      sent_cnt++;
    end
    // A stretch in the middle of the run goes without gaps.
    idle_ok = (sent_cnt < 150 || sent_cnt >= 270);
    if (!start || was_taken) begin
      if (rst_n && cmd_q.size() != 0 &&
          !(cmd_q[0].hold && walk_results.size() != 0) &&
          !(idle_ok && $urandom_range(0, 99) < 31)) begin
        cur_cmd = cmd_q[0];
        in_req_type <= cur_cmd.req;
        in_symbol <= cur_cmd.sym;
        in_code_bits <= cur_cmd.code;
        in_code_len <= cur_cmd.len;
        in_data_byte <= cur_cmd.data;
        in_valid_bits <= cur_cmd.vbits;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result strobe, then updates the shadow table on acceptance.
  always @(posedge clk) begin
    walk_res_t w;
    if (!rst_n) reset_tree();
    if (rst_n && out_valid) begin
      if (walk_results.size() == 0) begin
        $error("unexpected result: out_symbol %0d out_status %0d out_last %0d",
               out_symbol, out_status, out_last);
        fails++;
      end else begin
        w = walk_results.pop_front();
        if (out_symbol !== w.sym) begin
          $error("out_symbol: expected %0d, actual %0d", w.sym, out_symbol);
          fails++;
        end
        if (out_status !== w.status) begin
          $error("out_status: expected %0d, actual %0d", w.status, out_status);
          fails++;
        end
        if (out_last !== w.last) begin
          $error("out_last: expected %0d, actual %0d", w.last, out_last);
          fails++;
        end
        case (w.status)
          ST_SYMBOL:  n_sym++;
          ST_INVALID: n_invalid++;
          ST_DONE:    n_done++;
          default:    n_full++;
        endcase
      end
    end
    if (rst_n && start && !busy) begin
      n_taken++;
      case (cur_cmd.req)
        REQ_CLEAR: reset_tree();
        REQ_INSERT: begin
          w.sym = '0;
          w.status = grow_path(cur_cmd.sym, cur_cmd.code, cur_cmd.len);
          w.last = 1'b1;
          walk_results.insert(walk_results.size(), w);
        end
        REQ_DECODE: walk_byte(cur_cmd.data, cur_cmd.vbits);
        default: ;
      endcase
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    tree_cmd_t        c;
    logic [CODE_W-1:0] cw_val[$];
    int               cw_len[$];
    logic [SYM_W-1:0] cw_sym[$];
    int               order[$];
    logic             stream[$];
    logic [CODE_W-1:0] v;
    logic [BYTE_W-1:0] d;
    int               first_random;
    int               leaves, depth, pick, nsym, skip, kind, k, n, l, tmp, i, b;
    logic             deep;

    // Lone root: every bit is a missing child; then an empty byte and an unused code.
    queue_decode(8'hA5, 8);
    queue_decode(8'h00, 0);
    cmd_q.insert(cmd_q.size(), rand_cmd(REQ_UNUSED));
    // Empty path labels the root, then a small complete code 0, 10, 110, 111.
    queue_insert(7'd127, 32'd0, 0);
    queue_insert(7'd0, 32'd0, 1);
    queue_insert(7'd127, 32'b10, 2);
    queue_insert(7'd42, 32'b110, 3);
    queue_insert(7'd85, 32'b111, 3);
    // Codes across a byte boundary and more than eight valid bits.
    queue_decode(8'b01011011, 8);
    queue_decode(8'b10000000, 1);
    queue_decode(8'hFF, 15);
    // Relabel an inner node while the walk sits mid-code.
    queue_insert(7'd99, 32'b11, 2);
    queue_decode(8'h80, 1);
    c = rand_cmd(REQ_CLEAR);
    c.hold = 1'b1;
    cmd_q.insert(cmd_q.size(), c);
    // Eight long paths with distinct 3-bit prefixes leave nine free nodes.
    queue_insert(SYM_W'($urandom), 32'h0000_0000, 45);
    for (k = 1; k < 7; k++) begin
      queue_insert(SYM_W'($urandom), {k[2:0], 29'($urandom)}, 32);
    end
    queue_insert(SYM_W'($urandom), 32'hFFFF_FFFF, 32);
    // This path needs 29 new nodes, so the table runs full on the way.
    queue_insert(SYM_W'($urandom), 32'h1FFF_FFFF, 32);
    queue_insert(7'd5, 32'b101, 3);
    queue_decode(8'h00, 8);

    first_random = cmd_q.size();
    while (cmd_q.size() < first_random + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // Well-formed phase: fresh prefix code, then an encoded stream.
        c = rand_cmd(REQ_CLEAR);
        c.hold = (cmd_q.size() == first_random) || ($urandom_range(0, 3) == 0);
        cmd_q.insert(cmd_q.size(), c);
        deep = ($urandom_range(0, 7) == 0);
        leaves = deep ? $urandom_range(20, 33) : $urandom_range(2, 16);
        depth = deep ? 32 : 8;
        cw_val = {32'd0};
        cw_len = {0};
        while (cw_val.size() < leaves) begin
          pick = (deep && $urandom_range(0, 4) != 0) ? cw_val.size() - 1
                                                     : $urandom_range(0, cw_val.size() - 1);
          if (cw_len[pick] < depth) begin
            v = cw_val[pick];
            l = cw_len[pick];
            cw_val.delete(pick);
            cw_len.delete(pick);
            cw_val.insert(cw_val.size(), {v[CODE_W-2:0], 1'b0});
            cw_len.insert(cw_len.size(), l + 1);
            cw_val.insert(cw_val.size(), {v[CODE_W-2:0], 1'b1});
            cw_len.insert(cw_len.size(), l + 1);
          end
        end
        cw_sym.delete();
        order.delete();
        for (i = 0; i < leaves; i++) begin
          cw_sym.insert(cw_sym.size(), SYM_W'($urandom));
          order.insert(order.size(), i);
        end
        for (i = leaves - 1; i > 0; i--) begin
          pick = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[pick];
          order[pick] = tmp;
        end
        // Now and then one leaf is left out so its path is missing.
        skip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, leaves - 1) : -1;
        for (i = 0; i < leaves; i++) begin
          if (order[i] != skip) begin
            queue_insert(cw_sym[order[i]], cw_val[order[i]], cw_len[order[i]]);
          end
        end
        stream.delete();
        nsym = $urandom_range(3, 30);
        for (i = 0; i < nsym; i++) begin
          k = $urandom_range(0, leaves - 1);
          for (b = cw_len[k] - 1; b >= 0; b--) stream.insert(stream.size(), cw_val[k][b]);
        end
        while (stream.size() != 0) begin
          n = (stream.size() > 8) ? 8 : stream.size();
          d = BYTE_W'($urandom);
          for (b = 0; b < n; b++) d[7 - b] = stream.pop_front();
          if (n == 8 && $urandom_range(0, 4) == 0) n = $urandom_range(9, 15);
          queue_decode(d, n);
          // A relabel between bytes leaves the walk position where it is.
          if ($urandom_range(0, 15) == 0) begin
            k = $urandom_range(0, leaves - 1);
            queue_insert(SYM_W'($urandom), cw_val[k], cw_len[k]);
          end
        end
      end else begin
        // Noise phase: random transactions on top of whatever tree is there.
        n = $urandom_range(4, 16);
        for (i = 0; i < n; i++) begin
          kind = $urandom_range(0, 19);
          if (kind == 0) begin
            cmd_q.insert(cmd_q.size(), rand_cmd(REQ_CLEAR));
          end else if (kind == 1) begin
            cmd_q.insert(cmd_q.size(), rand_cmd(REQ_UNUSED));
          end else if (kind < 10) begin
            queue_insert(SYM_W'($urandom), $urandom,
                         ($urandom_range(0, 2) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 10));
          end else begin
            queue_decode(BYTE_W'($urandom), $urandom_range(0, 15));
          end
        end
      end
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (cmd_q.size() != 0 || start) @(negedge clk);
    while (walk_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d transactions through clears, inserts and byte decodes.", n_taken);
    $display("Seen: %0d symbols, %0d bad paths, %0d inserts done, %0d table-full results.",
             n_sym, n_invalid, n_done, n_full);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $error("timeout with %0d transactions queued and %0d results outstanding",
           cmd_q.size(), walk_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/core/htwd_pkg.sv
rtl/core/htwd_result_buf.sv
rtl/core/huffman_tree_walk_decoder.sv
bench/tb_top.sv
